// ----- rtl/core/cds_pkg.sv -----
// cds_pkg: shared types, constants and calendar helper functions
// used by the calendar date stepper controller, datapath and report unit
// no dependencies
package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;
    localparam int MASK_W  = 7;
    localparam int WD_W    = 3;
    localparam int DOY_W   = 9;

    // request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_DAYS   = 2'd1;
    localparam logic [1:0] REQ_MONTHS = 2'd2;

    localparam logic [MONTH_W-1:0] JAN = 4'd1;
    localparam logic [MONTH_W-1:0] FEB = 4'd2;
    localparam logic [MONTH_W-1:0] DEC = 4'd12;

    // 25 * INV25 == 1 mod 2^16, divisible by 25 when the product is <= DIV25_LIM
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_LIM = 16'd2621;

    // floor(x / 100) = (x * RECIP100) >> 21 for x < 2^15
    localparam logic [14:0] RECIP100 = 15'd20972;
    // floor(x / 7) = (x * RECIP7) >> 18 for x < 2^15
    localparam logic [15:0] RECIP7   = 16'd37450;

    typedef struct packed {
        logic accept;    // input transaction taken
        logic step;      // apply one single-day or single-month step
        logic cap1;      // report stage 1 capture
        logic cap2;      // report stage 2 capture
        logic load_out;  // move result into the output register
    } cds_cmd_t;

    typedef struct packed {
        logic start_step;  // accepted request has steps to run
        logic step_done;   // this step is the last one or it failed
        logic out_free;    // output register can take a new result
    } cds_stat_t;

    function automatic logic leap_of(input logic [YEAR_W-1:0] y);
        logic [15:0] prod;
        logic        div25;
        begin
            prod  = 16'({2'b00, y} * INV25);
            div25 = (prod <= DIV25_LIM);
            leap_of = (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'd0));
        end
    endfunction

    // zero when the month is outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
                4'd2:    month_len = leap ? 5'd29 : 5'd28;
                default: month_len = 5'd0;
            endcase
        end
    endfunction

    // days in the months before m, common year
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        begin
            unique case (m)
                4'd3:    days_before = 9'd31 + 9'd28;
                4'd4:    days_before = 9'd90;
                4'd5:    days_before = 9'd120;
                4'd6:    days_before = 9'd151;
                4'd7:    days_before = 9'd181;
                4'd8:    days_before = 9'd212;
                4'd9:    days_before = 9'd243;
                4'd10:   days_before = 9'd273;
                4'd11:   days_before = 9'd304;
                4'd12:   days_before = 9'd334;
                4'd2:    days_before = 9'd31;
                default: days_before = 9'd0;
            endcase
        end
    endfunction

    // (31 * mm) / 12 with mm the march-based month number
    function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
        begin
            unique case (m)
                4'd1:    month_term = 6'd28;
                4'd2:    month_term = 6'd31;
                4'd3:    month_term = 6'd2;
                4'd4:    month_term = 6'd5;
                4'd5:    month_term = 6'd7;
                4'd6:    month_term = 6'd10;
                4'd7:    month_term = 6'd12;
                4'd8:    month_term = 6'd15;
                4'd9:    month_term = 6'd18;
                4'd10:   month_term = 6'd20;
                4'd11:   month_term = 6'd23;
                4'd12:   month_term = 6'd25;
                default: month_term = 6'd0;
            endcase
        end
    endfunction

endpackage

// ----- rtl/core/calendar_date_stepper.sv -----
// calendar_date_stepper: top level, holds a Gregorian date and steps it
// by days or months; uses cds_pkg, cds_ctrl, cds_datapath and cds_report
//
// Usage:
// - input channel s_*: one transaction loads a date (req_type 0), steps
//   by days (1) or by months (2); req_type 3 only reports the date
// - result channel m_*: exactly one result transaction per input, carrying
//   the date, weekday, day of year, leap flag, month length, validity,
//   weekend flag and range error
// - cfg_wr_en/cfg_wr_data write the 7-bit weekend mask, one bit per weekday
// - sequencing: an accepted input runs its steps, then report stages CAP1
//   and CAP2, then HOLD loads the output register once it is free; the
//   single-step loop in the datapath runs one day or one month per clock
// - throughput: one transaction at a time; s_ready is high only while the
//   sequencer is idle, which it is again as soon as a result is loaded
// - the next input is taken while a result still sits in the output
//   register; if the receiver stalls, the finished report waits and the
//   sequencer holds until the output register frees
// - reset: date becomes 1 January 2000, weekend mask Friday and Saturday,
//   no result pending
module calendar_date_stepper
    import cds_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [MASK_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_step_back,
    input  logic [COUNT_W-1:0] s_step_count,
    input  logic [DAY_W-1:0]   s_load_day,
    input  logic [MONTH_W-1:0] s_load_month,
    input  logic [YEAR_W-1:0]  s_load_year,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DAY_W-1:0]   m_out_day,
    output logic [MONTH_W-1:0] m_out_month,
    output logic [YEAR_W-1:0]  m_out_year,
    output logic [WD_W-1:0]    m_weekday,
    output logic [DOY_W-1:0]   m_day_of_year,
    output logic               m_is_leap,
    output logic [DAY_W-1:0]   m_month_length,
    output logic               m_date_valid,
    output logic               m_is_weekend,
    output logic               m_range_error
);

    cds_cmd_t           cmd;
    cds_stat_t          stat;
    logic               dp_start_step;
    logic               dp_step_done;
    logic               rpt_out_free;
    logic [DAY_W-1:0]   cur_day;
    logic [MONTH_W-1:0] cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic               cur_leap;
    logic               cur_err;

    assign stat = {dp_start_step, dp_step_done, rpt_out_free};

    cds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cds_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_req_type   (s_req_type),
        .s_step_back  (s_step_back),
        .s_step_count (s_step_count),
        .s_load_day   (s_load_day),
        .s_load_month (s_load_month),
        .s_load_year  (s_load_year),
        .start_step   (dp_start_step),
        .step_done    (dp_step_done),
        .day          (cur_day),
        .month        (cur_month),
        .year         (cur_year),
        .leap         (cur_leap),
        .range_err    (cur_err)
    );

    cds_report u_report (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .out_free       (rpt_out_free),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .day            (cur_day),
        .month          (cur_month),
        .year           (cur_year),
        .leap           (cur_leap),
        .range_err      (cur_err),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_day      (m_out_day),
        .m_out_month    (m_out_month),
        .m_out_year     (m_out_year),
        .m_weekday      (m_weekday),
        .m_day_of_year  (m_day_of_year),
        .m_is_leap      (m_is_leap),
        .m_month_length (m_month_length),
        .m_date_valid   (m_date_valid),
        .m_is_weekend   (m_is_weekend),
        .m_range_error  (m_range_error)
    );

endmodule

// ----- rtl/core/cds_ctrl.sv -----
// cds_ctrl: sequencer for the calendar date stepper
// depends on cds_pkg for the command and status structs
module cds_ctrl
    import cds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cds_stat_t stat,
    output cds_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STEP = 5'b00010,
        ST_CAP1 = 5'b00100,
        ST_CAP2 = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.start_step ? ST_STEP : ST_CAP1;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (stat.step_done) begin
                    state_next = ST_CAP1;
                end
            end
            ST_CAP1: begin
                cmd.cap1   = 1'b1;
                state_next = ST_CAP2;
            end
            ST_CAP2: begin
                cmd.cap2   = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                // wait here while the previous result is still unclaimed
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/cds_datapath.sv -----
// cds_datapath: current date registers, step counter and single-step logic
// depends on cds_pkg for widths, request codes and calendar functions
module cds_datapath
    import cds_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cds_cmd_t           cmd,
    input  logic [1:0]         s_req_type,
    input  logic               s_step_back,
    input  logic [COUNT_W-1:0] s_step_count,
    input  logic [DAY_W-1:0]   s_load_day,
    input  logic [MONTH_W-1:0] s_load_month,
    input  logic [YEAR_W-1:0]  s_load_year,
    output logic               start_step,
    output logic               step_done,
    output logic [DAY_W-1:0]   day,
    output logic [MONTH_W-1:0] month,
    output logic [YEAR_W-1:0]  year,
    output logic               leap,
    output logic               range_err
);

    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               back_reg, back_next;
    logic               by_month_reg, by_month_next;
    logic               err_reg, err_next;

    logic               is_step_req;
    logic               fit;
    logic [DAY_W-1:0]   len_cur;
    logic [MONTH_W-1:0] month_prev, month_fwd, month_new;
    logic [DAY_W-1:0]   len_new;
    logic               top_wrap, bot_wrap;
    logic               fail;
    logic [DAY_W-1:0]   st_day;
    logic [MONTH_W-1:0] st_month;
    logic [YEAR_W-1:0]  st_year;

    assign leap    = leap_of(year_reg);
    assign len_cur = month_len(leap, month_reg);
    assign fit     = (len_cur != '0) && (day_reg != '0) && (day_reg <= len_cur)
                     && (year_reg != '0) && (year_reg <= MAX_Y);

    assign is_step_req = (s_req_type == REQ_DAYS) || (s_req_type == REQ_MONTHS);
    assign start_step  = is_step_req && fit && (s_step_count != '0);

    assign month_prev = (month_reg == JAN) ? DEC : month_reg - 4'd1;
    assign month_fwd  = (month_reg == DEC) ? JAN : month_reg + 4'd1;
    assign top_wrap   = (month_reg == DEC) && (year_reg >= MAX_Y);
    assign bot_wrap   = (month_reg == JAN) && (year_reg <= YEAR_W'(1));

    // the year only changes across december and january, so february
    // after a step always lies in the current year
    assign month_new = back_reg ? month_prev : month_fwd;
    assign len_new   = month_len(leap, month_new);

    always_comb begin
        st_day   = day_reg;
        st_month = month_reg;
        st_year  = year_reg;
        fail     = 1'b0;
        if (by_month_reg) begin
            fail     = back_reg ? bot_wrap : top_wrap;
            st_month = month_new;
            if (back_reg && month_reg == JAN) begin
                st_year = year_reg - YEAR_W'(1);
            end else if (!back_reg && month_reg == DEC) begin
                st_year = year_reg + YEAR_W'(1);
            end
            st_day = (len_new < day_reg) ? len_new : day_reg;
        end else if (back_reg) begin
            if (day_reg == DAY_W'(1)) begin
                fail     = bot_wrap;
                st_month = month_prev;
                st_day   = month_len(leap, month_prev);
                if (month_reg == JAN) begin
                    st_year = year_reg - YEAR_W'(1);
                end
            end else begin
                st_day = day_reg - DAY_W'(1);
            end
        end else begin
            if (day_reg == len_cur) begin
                fail     = top_wrap;
                st_month = month_fwd;
                st_day   = DAY_W'(1);
                if (month_reg == DEC) begin
                    st_year = year_reg + YEAR_W'(1);
                end
            end else begin
                st_day = day_reg + DAY_W'(1);
            end
        end
    end

    assign step_done = fail || (count_reg == COUNT_W'(1));

    always_comb begin
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        count_next    = count_reg;
        back_next     = back_reg;
        by_month_next = by_month_reg;
        err_next      = err_reg;
        if (cmd.accept) begin
            if (s_req_type == REQ_LOAD) begin
                day_next   = s_load_day;
                month_next = s_load_month;
                year_next  = s_load_year;
            end
            count_next    = s_step_count;
            back_next     = s_step_back;
            by_month_next = (s_req_type == REQ_MONTHS);
            err_next      = is_step_req && !fit;
        end else if (cmd.step) begin
            if (fail) begin
                err_next = 1'b1;
            end else begin
                day_next   = st_day;
                month_next = st_month;
                year_next  = st_year;
                count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg   <= DAY_W'(1);
            month_reg <= JAN;
            year_reg  <= YEAR_W'(2000);
            err_reg   <= 1'b0;
        end else begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        back_reg     <= back_next;
        by_month_reg <= by_month_next;
    end

    assign day       = day_reg;
    assign month     = month_reg;
    assign year      = year_reg;
    assign range_err = err_reg;

endmodule

// ----- rtl/core/cds_report.sv -----
// cds_report: two-stage derivation of weekday, day of year and flags,
// plus the weekend mask register and the output register; uses cds_pkg
module cds_report
    import cds_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cds_cmd_t           cmd,
    output logic               out_free,
    input  logic               cfg_wr_en,
    input  logic [MASK_W-1:0]  cfg_wr_data,
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    input  logic               leap,
    input  logic               range_err,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DAY_W-1:0]   m_out_day,
    output logic [MONTH_W-1:0] m_out_month,
    output logic [YEAR_W-1:0]  m_out_year,
    output logic [WD_W-1:0]    m_weekday,
    output logic [DOY_W-1:0]   m_day_of_year,
    output logic               m_is_leap,
    output logic [DAY_W-1:0]   m_month_length,
    output logic               m_date_valid,
    output logic               m_is_weekend,
    output logic               m_range_error
);

    logic [MASK_W-1:0]  mask_reg;
    logic               valid_out_reg;

    // stage 1
    logic [DAY_W-1:0]   s1_day_reg;
    logic [MONTH_W-1:0] s1_month_reg;
    logic [YEAR_W-1:0]  s1_year_reg;
    logic               s1_leap_reg;
    logic [DAY_W-1:0]   s1_len_reg;
    logic               s1_ok_reg;
    logic [DOY_W-1:0]   s1_doy_reg;
    logic               s1_err_reg;
    logic [14:0]        s1_yy_reg;
    logic [7:0]         s1_q100_reg;
    logic [5:0]         s1_mterm_reg;

    // stage 2
    logic [DAY_W-1:0]   s2_day_reg;
    logic [MONTH_W-1:0] s2_month_reg;
    logic [YEAR_W-1:0]  s2_year_reg;
    logic               s2_leap_reg;
    logic [DAY_W-1:0]   s2_len_reg;
    logic               s2_ok_reg;
    logic [DOY_W-1:0]   s2_doy_reg;
    logic               s2_err_reg;
    logic [14:0]        s2_sum_reg;
    logic [11:0]        s2_q7_reg;

    logic [DAY_W-1:0]   o_day_reg;
    logic [MONTH_W-1:0] o_month_reg;
    logic [YEAR_W-1:0]  o_year_reg;
    logic [WD_W-1:0]    o_wd_reg;
    logic [DOY_W-1:0]   o_doy_reg;
    logic               o_leap_reg;
    logic [DAY_W-1:0]   o_len_reg;
    logic               o_ok_reg;
    logic               o_wkend_reg;
    logic               o_err_reg;

    logic [DAY_W-1:0]   len;
    logic               ok;
    logic               early;
    logic [14:0]        yy;
    logic [29:0]        prod100;
    logic [DOY_W-1:0]   doy;
    logic [14:0]        sum;
    logic [30:0]        prod7;
    logic [14:0]        q7x7;
    logic [14:0]        rem7;
    logic [WD_W-1:0]    wd;

    assign len   = month_len(leap, month);
    assign ok    = (len != '0) && (day != '0) && (day <= len);
    assign early = (month <= FEB);
    // year shifted by 400 keeps every term positive
    assign yy      = 15'(year) + 15'd400 - 15'(early);
    assign prod100 = 30'(yy) * 30'(RECIP100);
    assign doy     = days_before(month) + 9'(day)
                     + 9'(leap && (month > FEB));

    assign sum = 15'(s1_day_reg) + s1_yy_reg + (s1_yy_reg >> 2)
                 - 15'(s1_q100_reg) + 15'(s1_q100_reg >> 2) + 15'(s1_mterm_reg);
    assign prod7 = 31'(sum) * 31'(RECIP7);

    assign q7x7 = {s2_q7_reg, 3'b000} - {3'b000, s2_q7_reg};
    assign rem7 = s2_sum_reg - q7x7;
    assign wd   = rem7[WD_W-1:0];

    assign out_free = !valid_out_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.cap1) begin
            s1_day_reg   <= day;
            s1_month_reg <= month;
            s1_year_reg  <= year;
            s1_leap_reg  <= leap;
            s1_len_reg   <= len;
            s1_ok_reg    <= ok;
            s1_doy_reg   <= doy;
            s1_err_reg   <= range_err;
            s1_yy_reg    <= yy;
            s1_q100_reg  <= prod100[28:21];
            s1_mterm_reg <= month_term(month);
        end
        if (cmd.cap2) begin
            s2_day_reg   <= s1_day_reg;
            s2_month_reg <= s1_month_reg;
            s2_year_reg  <= s1_year_reg;
            s2_leap_reg  <= s1_leap_reg;
            s2_len_reg   <= s1_len_reg;
            s2_ok_reg    <= s1_ok_reg;
            s2_doy_reg   <= s1_doy_reg;
            s2_err_reg   <= s1_err_reg;
            s2_sum_reg   <= sum;
            s2_q7_reg    <= prod7[29:18];
        end
        if (cmd.load_out) begin
            o_day_reg   <= s2_day_reg;
            o_month_reg <= s2_month_reg;
            o_year_reg  <= s2_year_reg;
            o_wd_reg    <= s2_ok_reg ? wd : '0;
            o_doy_reg   <= s2_ok_reg ? s2_doy_reg : '0;
            o_leap_reg  <= s2_leap_reg;
            o_len_reg   <= s2_len_reg;
            o_ok_reg    <= s2_ok_reg;
            o_wkend_reg <= s2_ok_reg && mask_reg[wd];
            o_err_reg   <= s2_err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= MASK_W'(96);
            valid_out_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mask_reg <= cfg_wr_data;
            end
            if (cmd.load_out) begin
                valid_out_reg <= 1'b1;
            end else if (m_ready) begin
                valid_out_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = valid_out_reg;
    assign m_out_day      = o_day_reg;
    assign m_out_month    = o_month_reg;
    assign m_out_year     = o_year_reg;
    assign m_weekday      = o_wd_reg;
    assign m_day_of_year  = o_doy_reg;
    assign m_is_leap      = o_leap_reg;
    assign m_month_length = o_len_reg;
    assign m_date_valid   = o_ok_reg;
    assign m_is_weekend   = o_wkend_reg;
    assign m_range_error  = o_err_reg;

endmodule

// ----- test/tb_date_checker.sv -----
`timescale 1ns / 1ps
// tb_date_checker: watches both channels of calendar_date_stepper, predicts each report
// from its own date state and weekend mask, and compares every result field
// depends on cds_pkg for field widths and request codes
module tb_date_checker
    import cds_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [MASK_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_step_back,
    input  logic [COUNT_W-1:0] s_step_count,
    input  logic [DAY_W-1:0]   s_load_day,
    input  logic [MONTH_W-1:0] s_load_month,
    input  logic [YEAR_W-1:0]  s_load_year,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [DAY_W-1:0]   m_out_day,
    input  logic [MONTH_W-1:0] m_out_month,
    input  logic [YEAR_W-1:0]  m_out_year,
    input  logic [WD_W-1:0]    m_weekday,
    input  logic [DOY_W-1:0]   m_day_of_year,
    input  logic               m_is_leap,
    input  logic [DAY_W-1:0]   m_month_length,
    input  logic               m_date_valid,
    input  logic               m_is_weekend,
    input  logic               m_range_error,
    output int                 pending_count,
    output int                 results_checked,
    output int                 mismatch_count
);

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WD_W-1:0]    wday;
        logic [DOY_W-1:0]   yday;
        logic               leap;
        logic [DAY_W-1:0]   mlen;
        logic               valid;
        logic               weekend;
        logic               range_err;
    } date_report_t;

    date_report_t      expected_reports[$];
    int                cal_d = 1;
    int                cal_m = 1;
    int                cal_y = 2000;
    logic [MASK_W-1:0] weekend_bits = 7'd96;

    initial begin
        pending_count   = 0;
        results_checked = 0;
        mismatch_count  = 0;
    end

    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // zero for a month outside 1..12
    function automatic int days_in(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_ok();
        int len;
        len = days_in(cal_y, cal_m);
        return (len != 0) && (cal_d >= 1) && (cal_d <= len);
    endfunction

    // march-based month count; year pushed up by 400 so nothing goes negative
    function automatic int weekday_of(int d, int m, int y);
        int yy, mm;
        yy = (m <= 2) ? y + 399 : y + 400;
        mm = (m <= 2) ? m + 10 : m - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    function automatic int ordinal_day(int d, int m, int y);
        int total;
        total = d;
        for (int i = 1; i < m && i <= 12; i++) begin
            total += days_in(y, i);
        end
        return total;
    endfunction

    function automatic bit move_one_day(bit back);
        if (!back) begin
            if (cal_d == days_in(cal_y, cal_m)) begin
                if (cal_m == 12) begin
                    if (cal_y >= MAX_YEAR) return 1'b0;
                    cal_y++;
                    cal_m = 1;
                end else begin
                    cal_m++;
                end
                cal_d = 1;
            end else begin
                cal_d++;
            end
        end else begin
            if (cal_d == 1) begin
                if (cal_m == 1) begin
                    if (cal_y <= 1) return 1'b0;
                    cal_y--;
                    cal_m = 12;
                end else begin
                    cal_m--;
                end
                cal_d = days_in(cal_y, cal_m);
            end else begin
                cal_d--;
            end
        end
        return 1'b1;
    endfunction

    // day is clamped after every single month, so clamping accumulates
    function automatic bit move_one_month(bit back);
        int len;
        if (back) begin
            if (cal_m == 1) begin
                if (cal_y <= 1) return 1'b0;
                cal_y--;
                cal_m = 12;
            end else begin
                cal_m--;
            end
        end else begin
            if (cal_m == 12) begin
                if (cal_y >= MAX_YEAR) return 1'b0;
                cal_y++;
                cal_m = 1;
            end else begin
                cal_m++;
            end
        end
        len = days_in(cal_y, cal_m);
        if (len < cal_d) cal_d = len;
        return 1'b1;
    endfunction

    function automatic date_report_t predict_report(logic [1:0] req, logic back,
                                                    logic [COUNT_W-1:0] count,
                                                    logic [DAY_W-1:0] ld,
                                                    logic [MONTH_W-1:0] lm,
                                                    logic [YEAR_W-1:0] ly);
        date_report_t r;
        bit           refused;
        bit           ok;
        int           wd;
        refused = 1'b0;
        if (req == REQ_LOAD) begin
            cal_d = int'(ld);
            cal_m = int'(lm);
            cal_y = int'(ly);
        end else if (req == REQ_DAYS || req == REQ_MONTHS) begin
            if (!date_ok() || cal_y < 1 || cal_y > MAX_YEAR) begin
                refused = 1'b1;
            end else begin
                for (int i = 0; i < int'(count); i++) begin
                    ok = (req == REQ_MONTHS) ? move_one_month(back) : move_one_day(back);
                    if (!ok) begin
                        refused = 1'b1;
                        break;
                    end
                end
            end
        end
        r           = '0;
        r.day       = DAY_W'(cal_d);
        r.month     = MONTH_W'(cal_m);
        r.year      = YEAR_W'(cal_y);
        r.leap      = leap_year(cal_y);
        r.mlen      = DAY_W'(days_in(cal_y, cal_m));
        r.range_err = refused;
        if (date_ok()) begin
            wd        = weekday_of(cal_d, cal_m, cal_y);
            r.valid   = 1'b1;
            r.wday    = WD_W'(wd);
            r.yday    = DOY_W'(ordinal_day(cal_d, cal_m, cal_y));
            r.weekend = weekend_bits[wd];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatch_count++;
        $display("%0t: mismatch on %s at report %0d: got %0d, expected %0d",
                 $time, field, results_checked, got, want);
    endtask

    task automatic check_report();
        date_report_t want;
        if (expected_reports.size() == 0) begin
            report_mismatch("unexpected report transaction", 1, 0);
            return;
        end
        want = expected_reports.pop_front();
        results_checked++;
        if (m_out_day !== want.day)
            report_mismatch("day", int'(m_out_day), int'(want.day));
        if (m_out_month !== want.month)
            report_mismatch("month", int'(m_out_month), int'(want.month));
        if (m_out_year !== want.year)
            report_mismatch("year", int'(m_out_year), int'(want.year));
        if (m_weekday !== want.wday)
            report_mismatch("weekday", int'(m_weekday), int'(want.wday));
        if (m_day_of_year !== want.yday)
            report_mismatch("day of year", int'(m_day_of_year), int'(want.yday));
        if (m_is_leap !== want.leap)
            report_mismatch("leap flag", int'(m_is_leap), int'(want.leap));
        if (m_month_length !== want.mlen)
            report_mismatch("month length", int'(m_month_length), int'(want.mlen));
        if (m_date_valid !== want.valid)
            report_mismatch("valid", int'(m_date_valid), int'(want.valid));
        if (m_is_weekend !== want.weekend)
            report_mismatch("weekend", int'(m_is_weekend), int'(want.weekend));
        if (m_range_error !== want.range_err)
            report_mismatch("range error", int'(m_range_error), int'(want.range_err));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cal_d        = 1;
            cal_m        = 1;
            cal_y        = 2000;
            weekend_bits = 7'd96;
            expected_reports.delete();
        end else begin
            if (cfg_wr_en) weekend_bits = cfg_wr_data;
            // a report never leaves in the cycle its request arrives, so pop first
            if (m_valid && m_ready) check_report();
            if (s_valid && s_ready)
                expected_reports.insert(expected_reports.size(),
                                        predict_report(s_req_type, s_step_back,
                                                       s_step_count, s_load_day,
                                                       s_load_month, s_load_year));
        end
        pending_count = expected_reports.size();
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for calendar_date_stepper; directed date edge cases,
// then random load/step sequences under four weekend masks; checking is in tb_date_checker
module tb_top;
    import cds_pkg::*;

    localparam int unsigned     MAX_YEAR   = 9999;
    localparam logic [1:0]      REQ_REPORT = 2'd3;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [MASK_W-1:0]  cfg_wr_data   = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type    = REQ_LOAD;
    logic               s_step_back   = 1'b0;
    logic [COUNT_W-1:0] s_step_count  = '0;
    logic [DAY_W-1:0]   s_load_day    = '0;
    logic [MONTH_W-1:0] s_load_month  = '0;
    logic [YEAR_W-1:0]  s_load_year   = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [DAY_W-1:0]   m_out_day;
    logic [MONTH_W-1:0] m_out_month;
    logic [YEAR_W-1:0]  m_out_year;
    logic [WD_W-1:0]    m_weekday;
    logic [DOY_W-1:0]   m_day_of_year;
    logic               m_is_leap;
    logic [DAY_W-1:0]   m_month_length;
    logic               m_date_valid;
    logic               m_is_weekend;
    logic               m_range_error;

    int     pending_count;
    int     results_checked;
    int     mismatch_count;
    int     items_sent  = 0;
    bit     steady      = 1'b0;
    longint cycle_count = 0;
    longint cycle_limit = 20000;

    calendar_date_stepper #(.MAX_YEAR(MAX_YEAR)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_step_back(s_step_back), .s_step_count(s_step_count),
        .s_load_day(s_load_day), .s_load_month(s_load_month), .s_load_year(s_load_year),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_day(m_out_day), .m_out_month(m_out_month), .m_out_year(m_out_year),
        .m_weekday(m_weekday), .m_day_of_year(m_day_of_year), .m_is_leap(m_is_leap),
        .m_month_length(m_month_length), .m_date_valid(m_date_valid),
        .m_is_weekend(m_is_weekend), .m_range_error(m_range_error)
    );

    tb_date_checker #(.MAX_YEAR(MAX_YEAR)) u_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_step_back(s_step_back), .s_step_count(s_step_count),
        .s_load_day(s_load_day), .s_load_month(s_load_month), .s_load_year(s_load_year),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_day(m_out_day), .m_out_month(m_out_month), .m_out_year(m_out_year),
        .m_weekday(m_weekday), .m_day_of_year(m_day_of_year), .m_is_leap(m_is_leap),
        .m_month_length(m_month_length), .m_date_valid(m_date_valid),
        .m_is_weekend(m_is_weekend), .m_range_error(m_range_error),
        .pending_count(pending_count), .results_checked(results_checked),
        .mismatch_count(mismatch_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 18);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles with %0d reports outstanding",
                     cycle_count, pending_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // returns once the transaction is taken, valid high unless an idle gap followed
    task automatic send_item(logic [1:0] req, logic back, logic [COUNT_W-1:0] count,
                             logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                             logic [YEAR_W-1:0] y);
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_step_back  <= back;
        s_step_count <= count;
        s_load_day   <= d;
        s_load_month <= m;
        s_load_year  <= y;
        cycle_limit  += 4 * longint'(count) + 200;
        items_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!steady && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            repeat (1 + $urandom_range(2)) @(posedge aclk);
        end
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic random_item();
        int                 sel;
        logic [1:0]         req;
        logic               back;
        logic [COUNT_W-1:0] count;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        sel   = $urandom_range(99);
        back  = 1'($urandom_range(1));
        count = COUNT_W'($urandom_range(65535));
        d     = DAY_W'($urandom_range(31));
        m     = MONTH_W'($urandom_range(15));
        y     = YEAR_W'($urandom_range(16383));
        if (sel < 12) begin
            req = REQ_LOAD;
        end else if (sel < 30) begin
            // mostly good dates, some close to either year bound
            req = REQ_LOAD;
            sel = $urandom_range(9);
            if (sel < 2)      y = YEAR_W'($urandom_range(3, 1));
            else if (sel < 4) y = YEAR_W'($urandom_range(MAX_YEAR, MAX_YEAR - 2));
            else              y = YEAR_W'($urandom_range(MAX_YEAR, 1));
            m = MONTH_W'($urandom_range(12, 1));
            d = ($urandom_range(3) == 0) ? DAY_W'($urandom_range(31, 29))
                                         : DAY_W'($urandom_range(28, 1));
        end else if (sel < 34) begin
            req = REQ_REPORT;
        end else begin
            req = ($urandom_range(1) == 0) ? REQ_DAYS : REQ_MONTHS;
            if ($urandom_range(24) == 0)  count = COUNT_W'($urandom_range(65535, 32768));
            else if (req == REQ_DAYS)     count = COUNT_W'($urandom_range(400));
            else                          count = COUNT_W'($urandom_range(40));
        end
        send_item(req, back, count, d, m, y);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part under the reset weekend mask
        send_item(REQ_REPORT, 1'b0, 16'd0, 5'd0, 4'd0, 14'd0);
        send_item(REQ_DAYS, 1'b0, 16'd0, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd29, 4'd2, 14'd2000);
        send_item(REQ_DAYS, 1'b0, 16'd1, 5'd0, 4'd0, 14'd0);
        send_item(REQ_DAYS, 1'b1, 16'd1, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd28, 4'd2, 14'd1900);
        send_item(REQ_DAYS, 1'b0, 16'd1, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd31, 4'd1, 14'd2023);
        send_item(REQ_MONTHS, 1'b0, 16'd1, 5'd0, 4'd0, 14'd0);
        send_item(REQ_MONTHS, 1'b0, 16'd2, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd31, 4'd12, 14'(MAX_YEAR));
        send_item(REQ_DAYS, 1'b0, 16'd5, 5'd0, 4'd0, 14'd0);
        send_item(REQ_MONTHS, 1'b0, 16'd1, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd1, 4'd1, 14'd1);
        send_item(REQ_MONTHS, 1'b1, 16'd3, 5'd0, 4'd0, 14'd0);
        send_item(REQ_DAYS, 1'b0, 16'hFFFF, 5'd0, 4'd0, 14'd0);
        send_item(REQ_DAYS, 1'b1, 16'd40000, 5'd0, 4'd0, 14'd0);
        // invalid dates and out-of-range years refuse any step
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd0, 4'd0, 14'd0);
        send_item(REQ_DAYS, 1'b1, 16'hFFFF, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b1, 16'hFFFF, 5'd31, 4'd15, 14'h3FFF);
        send_item(REQ_MONTHS, 1'b0, 16'd0, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd30, 4'd2, 14'd2024);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd15, 4'd6, 14'd0);
        send_item(REQ_DAYS, 1'b0, 16'd1, 5'd0, 4'd0, 14'd0);
        send_item(REQ_LOAD, 1'b0, 16'd0, 5'd1, 4'd1, 14'd10000);
        send_item(REQ_MONTHS, 1'b0, 16'd1, 5'd0, 4'd0, 14'd0);

        for (int phase = 0; phase < 4; phase++) begin
            drain_reports();
            cfg_wr_en <= 1'b1;
            case (phase)
                0:       cfg_wr_data <= 7'd0;
                1:       cfg_wr_data <= 7'h7F;
                2:       cfg_wr_data <= MASK_W'($urandom_range(127));
                default: cfg_wr_data <= 7'd96;
            endcase
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            // one whole phase runs with no idling on either side
            steady = (phase == 1);
            repeat (19) random_item();
        end
        steady = 1'b0;

        drain_reports();
        repeat (10) @(posedge aclk);
        $display("sent %0d requests (directed edge dates, then random load/step runs)",
                 items_sent);
        $display("checked %0d reports across four weekend masks", results_checked);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- calendar_date_stepper.f -----
rtl/core/cds_pkg.sv
rtl/core/cds_ctrl.sv
rtl/core/cds_datapath.sv
rtl/core/cds_report.sv
rtl/core/calendar_date_stepper.sv
test/tb_date_checker.sv
test/tb_top.sv
